>>> design/tcp_port_packet_filter_assert.svh
// Assertion macros shared by the filter modules.
// Simulation gets checking assertions; synthesis gets empty bodies.
`ifndef TCP_PORT_PACKET_FILTER_ASSERT_SVH
`define TCP_PORT_PACKET_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define TPF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TPF_ASSERT(label, clk, rst_n, prop, msg)
`define TPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> design/tpf_pkg.sv
package tpf_pkg;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } tpf_in_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] total_length;
    logic [7:0]  payload_offset;
  } tpf_out_t;

  // One finished frame as handed from the parser to the verdict stage.
  typedef struct packed {
    logic        ge_eth;
    logic        ge_proto;
    logic        ge_need;
    logic [15:0] ether_kind;
    logic [15:0] total_length;
    logic [7:0]  proto;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  payload_offset;
  } tpf_rec_t;

  typedef enum logic [2:0] {
    VERDICT_MATCH     = 3'd0,
    VERDICT_NOT_IPV4  = 3'd1,
    VERDICT_NOT_TCP   = 3'd2,
    VERDICT_MISMATCH  = 3'd3,
    VERDICT_TRUNCATED = 3'd4
  } tpf_verdict_t;

  localparam logic [1:0] CFG_MATCH_ETHERTYPE = 2'd0;
  localparam logic [1:0] CFG_MATCH_PROTOCOL  = 2'd1;
  localparam logic [1:0] CFG_MATCH_DEST_PORT = 2'd2;
  localparam logic [1:0] CFG_MIN_IP_LENGTH   = 2'd3;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [15:0] RST_MATCH_ETHERTYPE = 16'h0800;
  localparam logic [7:0]  RST_MATCH_PROTOCOL  = 8'd6;
  localparam logic [15:0] RST_MATCH_DEST_PORT = 16'd80;
  localparam logic [15:0] RST_MIN_IP_LENGTH   = 16'd50;

  // Byte positions of the captured header fields.
  localparam int ETH_TYPE_POS   = 12;
  localparam int IP_IHL_POS     = 14;
  localparam int IP_LEN_POS     = 16;
  localparam int IP_PROTO_POS   = 23;
  localparam int IP_SRC_POS     = 26;
  localparam int IP_DST_POS     = 30;
  localparam int ETH_HDR_BYTES  = 14;
  localparam int TCP_DOFF_POS   = 12;
  localparam int MIN_ETH_BYTES  = 14;
  localparam int MIN_PROTO_BYTES = 24;
  localparam int MIN_ADDR_BYTES = 34;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

endpackage

>>> design/tpf_queue.sv
`include "tcp_port_packet_filter_assert.svh"

module tpf_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tpf_pkg::tpf_rec_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output tpf_pkg::tpf_rec_t head_data
);

  tpf_pkg::tpf_rec_t                entry_r [tpf_pkg::QUEUE_DEPTH];
  logic [tpf_pkg::QUEUE_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [tpf_pkg::QUEUE_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [tpf_pkg::QUEUE_CW-1:0]     count_r, count_nxt;

  assign full       = (count_r == tpf_pkg::QUEUE_CW'(tpf_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + tpf_pkg::QUEUE_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + tpf_pkg::QUEUE_AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + tpf_pkg::QUEUE_CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - tpf_pkg::QUEUE_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  `TPF_ASSERT(a_no_push_full, clk, rst_n, push |-> !full,
              "frame record pushed into full queue")
  `TPF_ASSERT(a_no_pop_empty, clk, rst_n, pop |-> head_valid,
              "frame record popped from empty queue")
  `TPF_ASSERT_NEXT(a_pop_count, clk, rst_n, pop && !push,
                   count_r == $past(count_r) - tpf_pkg::QUEUE_CW'(1),
                   "queue count did not drop on pop")

endmodule

>>> design/tpf_front.sv
module tpf_front #(
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tpf_pkg::tpf_in_t  in_data,
  input  logic              queue_full,
  output logic              push,
  output tpf_pkg::tpf_rec_t push_data
);

  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      ether_kind_r, ether_kind_nxt;
  logic [5:0]       ihb_r, ihb_nxt;
  logic [15:0]      ip_total_r, ip_total_nxt;
  logic [7:0]       proto_r, proto_nxt;
  logic [31:0]      src_addr_r, src_addr_nxt;
  logic [31:0]      dst_addr_r, dst_addr_nxt;
  logic [15:0]      src_port_r, src_port_nxt;
  logic [15:0]      dst_port_r, dst_port_nxt;
  logic [5:0]       tcp_hb_r, tcp_hb_nxt;

  logic [7:0]       b;
  logic             cap_en;
  logic             in_fire;
  logic [6:0]       tcp_start;
  logic [6:0]       tcp_need;
  logic [6:0]       need;
  logic [POS_W-1:0] t_pos;

  assign in_stall = queue_full;
  assign in_fire  = in_valid && !queue_full;
  assign push     = in_fire && in_data.last_byte;

  always_comb begin
    b      = in_data.frame_byte;
    cap_en = (pos_r < POS_MAX);

    ether_kind_nxt = ether_kind_r;
    ihb_nxt        = ihb_r;
    ip_total_nxt   = ip_total_r;
    proto_nxt      = proto_r;
    src_addr_nxt   = src_addr_r;
    dst_addr_nxt   = dst_addr_r;
    src_port_nxt   = src_port_r;
    dst_port_nxt   = dst_port_r;
    tcp_hb_nxt     = tcp_hb_r;

    if (cap_en && (pos_r == POS_W'(tpf_pkg::IP_IHL_POS))) begin
      ihb_nxt = {b[3:0], 2'b00};
    end
    // The TCP header start follows the header length written by this very byte.
    tcp_start = 7'(tpf_pkg::ETH_HDR_BYTES) + 7'(ihb_nxt);
    t_pos     = POS_W'(tcp_start);

    if (cap_en) begin
      if (pos_r == POS_W'(tpf_pkg::ETH_TYPE_POS) ||
          pos_r == POS_W'(tpf_pkg::ETH_TYPE_POS + 1)) begin
        ether_kind_nxt = {ether_kind_r[7:0], b};
      end
      if (pos_r == POS_W'(tpf_pkg::IP_LEN_POS) ||
          pos_r == POS_W'(tpf_pkg::IP_LEN_POS + 1)) begin
        ip_total_nxt = {ip_total_r[7:0], b};
      end
      if (pos_r == POS_W'(tpf_pkg::IP_PROTO_POS)) begin
        proto_nxt = b;
      end
      if (pos_r >= POS_W'(tpf_pkg::IP_SRC_POS) &&
          pos_r <= POS_W'(tpf_pkg::IP_SRC_POS + 3)) begin
        src_addr_nxt = {src_addr_r[23:0], b};
      end
      if (pos_r >= POS_W'(tpf_pkg::IP_DST_POS) &&
          pos_r <= POS_W'(tpf_pkg::IP_DST_POS + 3)) begin
        dst_addr_nxt = {dst_addr_r[23:0], b};
      end
      if (pos_r == t_pos || pos_r == t_pos + POS_W'(1)) begin
        src_port_nxt = {src_port_r[7:0], b};
      end
      if (pos_r == t_pos + POS_W'(2) || pos_r == t_pos + POS_W'(3)) begin
        dst_port_nxt = {dst_port_r[7:0], b};
      end
      if (pos_r == t_pos + POS_W'(tpf_pkg::TCP_DOFF_POS)) begin
        tcp_hb_nxt = {b[7:4], 2'b00};
      end
    end

    pos_nxt  = cap_en ? pos_r + POS_W'(1) : pos_r;
    tcp_need = tcp_start + 7'(tpf_pkg::TCP_DOFF_POS + 1);
    need     = (tcp_need > 7'(tpf_pkg::MIN_ADDR_BYTES)) ? tcp_need
                                                         : 7'(tpf_pkg::MIN_ADDR_BYTES);

    push_data.ge_eth         = (pos_nxt >= POS_W'(tpf_pkg::MIN_ETH_BYTES));
    push_data.ge_proto       = (pos_nxt >= POS_W'(tpf_pkg::MIN_PROTO_BYTES));
    push_data.ge_need        = (pos_nxt >= POS_W'(need));
    push_data.ether_kind     = ether_kind_nxt;
    push_data.total_length   = ip_total_nxt;
    push_data.proto          = proto_nxt;
    push_data.src_addr       = src_addr_nxt;
    push_data.dst_addr       = dst_addr_nxt;
    push_data.src_port       = src_port_nxt;
    push_data.dst_port       = dst_port_nxt;
    push_data.payload_offset = 8'(tcp_start) + 8'(tcp_hb_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && in_data.last_byte)) begin
      pos_r        <= '0;
      ether_kind_r <= '0;
      ihb_r        <= '0;
      ip_total_r   <= '0;
      proto_r      <= '0;
      src_addr_r   <= '0;
      dst_addr_r   <= '0;
      src_port_r   <= '0;
      dst_port_r   <= '0;
      tcp_hb_r     <= '0;
    end else if (in_fire) begin
      pos_r        <= pos_nxt;
      ether_kind_r <= ether_kind_nxt;
      ihb_r        <= ihb_nxt;
      ip_total_r   <= ip_total_nxt;
      proto_r      <= proto_nxt;
      src_addr_r   <= src_addr_nxt;
      dst_addr_r   <= dst_addr_nxt;
      src_port_r   <= src_port_nxt;
      dst_port_r   <= dst_port_nxt;
      tcp_hb_r     <= tcp_hb_nxt;
    end
  end

endmodule

>>> design/tpf_back.sv
`include "tcp_port_packet_filter_assert.svh"

module tpf_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [tpf_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [tpf_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 head_valid,
  input  tpf_pkg::tpf_rec_t                    head_data,
  output logic                                 pop,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output tpf_pkg::tpf_out_t                    out_data
);

  logic [15:0] match_ethertype_r;
  logic [7:0]  match_protocol_r;
  logic [15:0] match_dest_port_r;
  logic [15:0] min_ip_length_r;

  logic              out_valid_r, out_valid_nxt;
  tpf_pkg::tpf_out_t out_data_r, out_data_nxt;
  tpf_pkg::tpf_verdict_t verdict;

  assign pop       = head_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    if (!head_data.ge_eth) begin
      verdict = tpf_pkg::VERDICT_TRUNCATED;
    end else if (head_data.ether_kind != match_ethertype_r) begin
      verdict = tpf_pkg::VERDICT_NOT_IPV4;
    end else if (!head_data.ge_proto) begin
      verdict = tpf_pkg::VERDICT_TRUNCATED;
    end else if (head_data.proto != match_protocol_r) begin
      verdict = tpf_pkg::VERDICT_NOT_TCP;
    end else if (!head_data.ge_need) begin
      verdict = tpf_pkg::VERDICT_TRUNCATED;
    end else if (head_data.dst_port != match_dest_port_r ||
                 head_data.total_length <= min_ip_length_r) begin
      verdict = tpf_pkg::VERDICT_MISMATCH;
    end else begin
      verdict = tpf_pkg::VERDICT_MATCH;
    end

    // Only a match or a mismatch carries the captured fields.
    out_data_nxt         = '0;
    out_data_nxt.verdict = verdict;
    if (verdict == tpf_pkg::VERDICT_MATCH || verdict == tpf_pkg::VERDICT_MISMATCH) begin
      out_data_nxt.source_address = head_data.src_addr;
      out_data_nxt.dest_address   = head_data.dst_addr;
      out_data_nxt.source_port    = head_data.src_port;
      out_data_nxt.dest_port      = head_data.dst_port;
      out_data_nxt.total_length   = head_data.total_length;
      out_data_nxt.payload_offset = head_data.payload_offset;
    end

    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_ethertype_r <= tpf_pkg::RST_MATCH_ETHERTYPE;
      match_protocol_r  <= tpf_pkg::RST_MATCH_PROTOCOL;
      match_dest_port_r <= tpf_pkg::RST_MATCH_DEST_PORT;
      min_ip_length_r   <= tpf_pkg::RST_MIN_IP_LENGTH;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tpf_pkg::CFG_MATCH_ETHERTYPE: match_ethertype_r <= cfg_data;
        tpf_pkg::CFG_MATCH_PROTOCOL:  match_protocol_r  <= cfg_data[7:0];
        tpf_pkg::CFG_MATCH_DEST_PORT: match_dest_port_r <= cfg_data;
        tpf_pkg::CFG_MIN_IP_LENGTH:   min_ip_length_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  `TPF_ASSERT(a_match_port, clk, rst_n,
              (out_valid_r && out_data_r.verdict == tpf_pkg::VERDICT_MATCH) |->
                (out_data_r.dest_port == match_dest_port_r),
              "match reported with wrong destination port")

endmodule

>>> design/tcp_port_packet_filter.sv
// Ethernet/IPv4/TCP header filter.
// The input channel (in_valid, in_stall, in_data) carries one frame byte per
// transaction in wire order; in_data.last_byte marks the final byte. The
// result channel (out_valid, out_stall, out_data) carries one verdict per
// frame with the IPv4 addresses, TCP ports, total length and payload offset.
// Verdicts other than match and mismatch carry zero fields.
// A byte is taken every cycle while in_stall is low. The parser registers the
// captured fields of a frame on its last byte into a two-entry queue; the
// verdict stage registers the result, so a result goes from the queue entry to
// the output register when the receiver is not stalling. Sustained rate, with
// no stall, is one byte per cycle and one verdict per cycle for one-byte frames.
// While out_stall is high the result holds and the queue fills; in_stall
// rises only when the queue is full, so the parser keeps taking bytes until
// two finished frames wait behind a stalled result.
// The cfg_ port writes match registers; write only while no frame is pending.
// Synchronous reset clears frame state and the queue and restores register
// defaults; no clearing pass is needed, the block accepts bytes right away.
module tcp_port_packet_filter #(
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tpf_pkg::tpf_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output tpf_pkg::tpf_out_t               out_data,
  input  logic                            cfg_wr_en,
  input  logic [tpf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tpf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic              push;
  logic              pop;
  logic              queue_full;
  logic              head_valid;
  tpf_pkg::tpf_rec_t push_data;
  tpf_pkg::tpf_rec_t head_data;

  tpf_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  tpf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  tpf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

>>> tb/tb_top.sv
module tb_top;

  localparam int FRAME_LIMIT   = 96;
  localparam int STUCK_LIMIT   = 3000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_PHASES = 6;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  tpf_pkg::tpf_in_t                in_data;
  logic                            out_valid;
  logic                            out_stall;
  tpf_pkg::tpf_out_t               out_data;
  logic                            cfg_wr_en;
  logic [tpf_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [tpf_pkg::CFG_DATA_W-1:0]  cfg_data;

  tcp_port_packet_filter #(.MAX_FRAME_BYTES(FRAME_LIMIT)) u_top (.*);

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // One frame to send: header fields are placed at their positions, the rest is random fill.
  typedef struct {
    int                    len;
    logic [15:0]           ethertype;
    logic [3:0]            ihl;
    logic [15:0]           ip_len;
    logic [7:0]            proto;
    logic [31:0]           src;
    logic [31:0]           dst;
    logic [15:0]           sport;
    logic [15:0]           dport;
    logic [3:0]            doff;
    bit                    fixed;
    tpf_pkg::tpf_verdict_t fixed_verdict;
  } frame_row_t;

  // Rows marked fixed carry a verdict that follows from the header alone; their other
  // fields are all zero. The remaining rows are checked against the header predictor.
  frame_row_t directed_rows [18] = '{
    '{1,    16'h0800, 4'd5,  16'd60,    8'd6,  32'h0A000001, 32'h0A000002, 16'd1234,
      16'd80, 4'd5, 1'b1, tpf_pkg::VERDICT_TRUNCATED},
    '{13,   16'h0800, 4'd5,  16'd60,    8'd6,  32'h0A000001, 32'h0A000002, 16'd1234,
      16'd80, 4'd5, 1'b1, tpf_pkg::VERDICT_TRUNCATED},
    '{14,   16'h0800, 4'd5,  16'd60,    8'd6,  32'h0A000001, 32'h0A000002, 16'd1234,
      16'd80, 4'd5, 1'b1, tpf_pkg::VERDICT_TRUNCATED},
    '{20,   16'h86DD, 4'd5,  16'd60,    8'd6,  32'h0A000001, 32'h0A000002, 16'd1234,
      16'd80, 4'd5, 1'b1, tpf_pkg::VERDICT_NOT_IPV4},
    '{14,   16'hFFFF, 4'd5,  16'd60,    8'd6,  32'h0A000001, 32'h0A000002, 16'd1234,
      16'd80, 4'd5, 1'b1, tpf_pkg::VERDICT_NOT_IPV4},
    '{16,   16'h0000, 4'd5,  16'd60,    8'd6,  32'h0A000001, 32'h0A000002, 16'd1234,
      16'd80, 4'd5, 1'b1, tpf_pkg::VERDICT_NOT_IPV4},
    '{23,   16'h0800, 4'd5,  16'd60,    8'd17, 32'h0A000001, 32'h0A000002, 16'd1234,
      16'd80, 4'd5, 1'b1, tpf_pkg::VERDICT_TRUNCATED},
    '{24,   16'h0800, 4'd5,  16'd60,    8'd17, 32'h0A000001, 32'h0A000002, 16'd1234,
      16'd80, 4'd5, 1'b1, tpf_pkg::VERDICT_NOT_TCP},
    '{46,   16'h0800, 4'd5,  16'd60,    8'd6,  32'h0A000001, 32'h0A000002, 16'd1234,
      16'd80, 4'd5, 1'b1, tpf_pkg::VERDICT_TRUNCATED},
    '{47,   16'h0800, 4'd5,  16'd60,    8'd6,  32'hC0A80001, 32'hC0A80102, 16'd40000,
      16'd80, 4'd5, 1'b0, tpf_pkg::VERDICT_MATCH},
    '{48,   16'h0800, 4'd5,  16'd50,    8'd6,  32'h0A000001, 32'h0A000002, 16'd1234,
      16'd80, 4'd5, 1'b0, tpf_pkg::VERDICT_MATCH},
    '{48,   16'h0800, 4'd5,  16'd0,     8'd6,  32'h0A000001, 32'h0A000002, 16'd1234,
      16'd81, 4'd5, 1'b0, tpf_pkg::VERDICT_MATCH},
    '{86,   16'h0800, 4'd15, 16'd200,   8'd6,  32'h0A000001, 32'h0A000002, 16'd1234,
      16'd80, 4'd8, 1'b1, tpf_pkg::VERDICT_TRUNCATED},
    '{89,   16'h0800, 4'd15, 16'd200,   8'd6,  32'h01020304, 32'h05060708, 16'd22,
      16'd80, 4'd15, 1'b0, tpf_pkg::VERDICT_MATCH},
    '{36,   16'h0800, 4'd0,  16'h0050,  8'd6,  32'h0A000001, 32'h0A000002, 16'd1234,
      16'd80, 4'd5, 1'b0, tpf_pkg::VERDICT_MATCH},
    '{36,   16'h0800, 4'd2,  16'd60,    8'd6,  32'h0A000001, 32'h0A000002, 16'd1234,
      16'd80, 4'd7, 1'b0, tpf_pkg::VERDICT_MATCH},
    '{52,   16'h0800, 4'd5,  16'hFFFF,  8'd6,  32'hFFFFFFFF, 32'h00000000, 16'hFFFF,
      16'd80, 4'd15, 1'b0, tpf_pkg::VERDICT_MATCH},
    '{110,  16'h0800, 4'd5,  16'd1500,  8'd6,  32'h00000000, 32'hFFFFFFFF, 16'h0000,
      16'd80, 4'd0, 1'b0, tpf_pkg::VERDICT_MATCH}
  };

  // Register copies and frame state of the header predictor.
  logic [15:0] want_ethertype;
  logic [7:0]  want_protocol;
  logic [15:0] want_dest_port;
  logic [15:0] min_length;
  int          seen_bytes;
  logic [15:0] ether_kind_q;
  logic [5:0]  ihl_bytes_q;
  logic [15:0] ip_len_q;
  logic [7:0]  proto_q;
  logic [31:0] src_q;
  logic [31:0] dst_q;
  logic [15:0] sport_q;
  logic [15:0] dport_q;
  logic [5:0]  doff_bytes_q;

  tpf_pkg::tpf_out_t pending_verdicts [$];
  tpf_pkg::tpf_out_t due_result;

  int mismatches = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int settings_done = 0;
  int verdict_seen [8] = '{default: 0};
  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  int hold_asked = 0;
  int hold_given = 0;
  int hold_left = 0;
  int stuck_cycles = 0;

  task automatic clear_frame();
    seen_bytes = 0;
    ether_kind_q = '0;
    ihl_bytes_q = '0;
    ip_len_q = '0;
    proto_q = '0;
    src_q = '0;
    dst_q = '0;
    sport_q = '0;
    dport_q = '0;
    doff_bytes_q = '0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic lst,
                            output logic got, output tpf_pkg::tpf_out_t res);
    int p;
    int t;
    int need;
    tpf_pkg::tpf_verdict_t v;
    got = 1'b0;
    res = '0;
    if (seen_bytes < FRAME_LIMIT) begin
      p = seen_bytes;
      if (p == tpf_pkg::ETH_TYPE_POS || p == tpf_pkg::ETH_TYPE_POS + 1)
        ether_kind_q = {ether_kind_q[7:0], b};
      if (p == tpf_pkg::IP_IHL_POS) ihl_bytes_q = {b[3:0], 2'b00};
      if (p == tpf_pkg::IP_LEN_POS || p == tpf_pkg::IP_LEN_POS + 1)
        ip_len_q = {ip_len_q[7:0], b};
      if (p == tpf_pkg::IP_PROTO_POS) proto_q = b;
      if (p >= tpf_pkg::IP_SRC_POS && p < tpf_pkg::IP_SRC_POS + 4) src_q = {src_q[23:0], b};
      if (p >= tpf_pkg::IP_DST_POS && p < tpf_pkg::IP_DST_POS + 4) dst_q = {dst_q[23:0], b};
      // The TCP header follows the IP header length as known after this byte.
      t = tpf_pkg::ETH_HDR_BYTES + ihl_bytes_q;
      if (p == t || p == t + 1) sport_q = {sport_q[7:0], b};
      if (p == t + 2 || p == t + 3) dport_q = {dport_q[7:0], b};
      if (p == t + tpf_pkg::TCP_DOFF_POS) doff_bytes_q = {b[7:4], 2'b00};
      seen_bytes++;
    end
    if (lst) begin
      t = tpf_pkg::ETH_HDR_BYTES + ihl_bytes_q;
      need = (t + tpf_pkg::TCP_DOFF_POS + 1 > tpf_pkg::MIN_ADDR_BYTES) ?
             t + tpf_pkg::TCP_DOFF_POS + 1 : tpf_pkg::MIN_ADDR_BYTES;
      if (seen_bytes < tpf_pkg::MIN_ETH_BYTES) v = tpf_pkg::VERDICT_TRUNCATED;
      else if (ether_kind_q != want_ethertype) v = tpf_pkg::VERDICT_NOT_IPV4;
      else if (seen_bytes < tpf_pkg::MIN_PROTO_BYTES) v = tpf_pkg::VERDICT_TRUNCATED;
      else if (proto_q != want_protocol) v = tpf_pkg::VERDICT_NOT_TCP;
      else if (seen_bytes < need) v = tpf_pkg::VERDICT_TRUNCATED;
      else if (dport_q != want_dest_port || ip_len_q <= min_length)
        v = tpf_pkg::VERDICT_MISMATCH;
      else v = tpf_pkg::VERDICT_MATCH;
      res.verdict = v;
      if (v == tpf_pkg::VERDICT_MATCH || v == tpf_pkg::VERDICT_MISMATCH) begin
        res.source_address = src_q;
        res.dest_address = dst_q;
        res.source_port = sport_q;
        res.dest_port = dport_q;
        res.total_length = ip_len_q;
        res.payload_offset = 8'(t + doff_bytes_q);
      end
      got = 1'b1;
      clear_frame();
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic lst,
                           output logic got, output tpf_pkg::tpf_out_t res);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{frame_byte: b, last_byte: lst};
    do @(posedge clk); while (in_stall);
    parse_byte(b, lst, got, res);
    bytes_sent++;
  endtask

  function automatic void place(ref logic [7:0] fb [], input int pos, input logic [7:0] v);
    if (pos < fb.size()) fb[pos] = v;
  endfunction

  task automatic send_frame(input frame_row_t r);
    logic [7:0] fb [];
    int t;
    logic got;
    tpf_pkg::tpf_out_t res;
    fb = new[r.len];
    foreach (fb[i]) fb[i] = 8'($urandom);
    t = tpf_pkg::ETH_HDR_BYTES + 4 * r.ihl;
    // TCP fields first, so that with a short IP header the IP fields win the overlap.
    place(fb, t, r.sport[15:8]);
    place(fb, t + 1, r.sport[7:0]);
    place(fb, t + 2, r.dport[15:8]);
    place(fb, t + 3, r.dport[7:0]);
    place(fb, t + tpf_pkg::TCP_DOFF_POS, {r.doff, 4'($urandom)});
    place(fb, tpf_pkg::ETH_TYPE_POS, r.ethertype[15:8]);
    place(fb, tpf_pkg::ETH_TYPE_POS + 1, r.ethertype[7:0]);
    place(fb, tpf_pkg::IP_IHL_POS, {4'($urandom), r.ihl});
    place(fb, tpf_pkg::IP_LEN_POS, r.ip_len[15:8]);
    place(fb, tpf_pkg::IP_LEN_POS + 1, r.ip_len[7:0]);
    place(fb, tpf_pkg::IP_PROTO_POS, r.proto);
    for (int k = 0; k < 4; k++) begin
      place(fb, tpf_pkg::IP_SRC_POS + k, r.src[31 - 8 * k -: 8]);
      place(fb, tpf_pkg::IP_DST_POS + k, r.dst[31 - 8 * k -: 8]);
    end
    foreach (fb[i]) begin
      send_byte(fb[i], i == fb.size() - 1, got, res);
      if (got) begin
        if (r.fixed) begin
          res = '0;
          res.verdict = r.fixed_verdict;
        end
        pending_verdicts.push_back(res);
      end
    end
    frames_sent++;
  endtask

  function automatic frame_row_t random_row();
    frame_row_t r;
    int roll;
    int t;
    int need;
    roll = $urandom_range(99);
    r.ethertype = ($urandom_range(9) != 0) ? want_ethertype : 16'($urandom);
    r.proto = ($urandom_range(9) != 0) ? want_protocol : 8'($urandom);
    r.ihl = ($urandom_range(9) < 7) ? 4'd5 : 4'($urandom);
    r.dport = ($urandom_range(3) != 0) ? want_dest_port : 16'($urandom);
    if (min_length != 16'hFFFF && $urandom_range(4) != 0)
      r.ip_len = 16'($urandom_range(65535, 32'(min_length) + 1));
    else
      r.ip_len = 16'($urandom_range(32'(min_length), 0));
    r.src = $urandom;
    r.dst = $urandom;
    r.sport = 16'($urandom);
    r.doff = 4'($urandom);
    r.fixed = 1'b0;
    r.fixed_verdict = tpf_pkg::VERDICT_MATCH;
    t = tpf_pkg::ETH_HDR_BYTES + 4 * r.ihl;
    need = (t + tpf_pkg::TCP_DOFF_POS + 1 > tpf_pkg::MIN_ADDR_BYTES) ?
           t + tpf_pkg::TCP_DOFF_POS + 1 : tpf_pkg::MIN_ADDR_BYTES;
    if (roll < 18) begin
      // Short noise frames, half of them with a random ethertype.
      r.len = $urandom_range(30, 1);
      if ($urandom_range(1) != 0) r.ethertype = 16'($urandom);
    end else if (roll < 19) begin
      r.len = $urandom_range(FRAME_LIMIT + 60, FRAME_LIMIT + 1);
    end else if (roll < 28) begin
      r.len = $urandom_range(need - 1, 1);
    end else begin
      r.len = need + $urandom_range(24, 0);
    end
    return r;
  endfunction

  task automatic drop_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    drop_valid();
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tpf_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [15:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      tpf_pkg::CFG_MATCH_ETHERTYPE: want_ethertype = val;
      tpf_pkg::CFG_MATCH_PROTOCOL:  want_protocol = val[7:0];
      tpf_pkg::CFG_MATCH_DEST_PORT: want_dest_port = val;
      tpf_pkg::CFG_MIN_IP_LENGTH:   min_length = val;
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] seen);
    if (want !== seen) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, seen);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      verdict_seen[out_data.verdict]++;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result transaction with nothing expected, actual %p", $time, out_data);
        mismatches++;
      end else begin
        due_result = pending_verdicts.pop_front();
        check_field("verdict", 32'(due_result.verdict), 32'(out_data.verdict));
        check_field("source_address", due_result.source_address, out_data.source_address);
        check_field("dest_address", due_result.dest_address, out_data.dest_address);
        check_field("source_port", 32'(due_result.source_port), 32'(out_data.source_port));
        check_field("dest_port", 32'(due_result.dest_port), 32'(out_data.dest_port));
        check_field("total_length", 32'(due_result.total_length),
                    32'(out_data.total_length));
        check_field("payload_offset", 32'(due_result.payload_offset),
                    32'(out_data.payload_offset));
      end
    end
  end

  // The receiver stalls at random, or for a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_given) begin
      hold_given <= hold_asked;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_gap_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int nframes;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    want_ethertype = tpf_pkg::RST_MATCH_ETHERTYPE;
    want_protocol = tpf_pkg::RST_MATCH_PROTOCOL;
    want_dest_port = tpf_pkg::RST_MATCH_DEST_PORT;
    min_length = tpf_pkg::RST_MIN_IP_LENGTH;
    clear_frame();
    send_gap_pct = 28;
    recv_gap_pct = 57;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) send_frame(directed_rows[i]);
    wait_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      send_gap_pct = (ph < 2) ? 28 : (ph < 4) ? 57 : 0;
      recv_gap_pct = (ph < 2) ? 57 : (ph < 4) ? 28 : 0;
      case (ph)
        0: begin
          write_reg(tpf_pkg::CFG_MATCH_ETHERTYPE, tpf_pkg::RST_MATCH_ETHERTYPE);
          write_reg(tpf_pkg::CFG_MATCH_PROTOCOL, 16'(tpf_pkg::RST_MATCH_PROTOCOL));
          write_reg(tpf_pkg::CFG_MATCH_DEST_PORT, tpf_pkg::RST_MATCH_DEST_PORT);
          write_reg(tpf_pkg::CFG_MIN_IP_LENGTH, tpf_pkg::RST_MIN_IP_LENGTH);
        end
        1: begin
          write_reg(tpf_pkg::CFG_MATCH_ETHERTYPE, 16'hFFFF);
          write_reg(tpf_pkg::CFG_MATCH_PROTOCOL, 16'hFFFF);
          write_reg(tpf_pkg::CFG_MATCH_DEST_PORT, 16'hFFFF);
          write_reg(tpf_pkg::CFG_MIN_IP_LENGTH, 16'hFFFF);
        end
        2: begin
          write_reg(tpf_pkg::CFG_MATCH_ETHERTYPE, 16'h0000);
          write_reg(tpf_pkg::CFG_MATCH_PROTOCOL, 16'h0000);
          write_reg(tpf_pkg::CFG_MATCH_DEST_PORT, 16'h0000);
          write_reg(tpf_pkg::CFG_MIN_IP_LENGTH, 16'h0000);
        end
        default: begin
          write_reg(tpf_pkg::CFG_MATCH_ETHERTYPE, 16'($urandom));
          write_reg(tpf_pkg::CFG_MATCH_PROTOCOL, 16'($urandom));
          write_reg(tpf_pkg::CFG_MATCH_DEST_PORT, 16'($urandom));
          write_reg(tpf_pkg::CFG_MIN_IP_LENGTH, 16'($urandom));
        end
      endcase
      settings_done++;
      // A long receiver hold-off while frames keep coming fills the block up.
      if (ph == 1) hold_asked++;
      nframes = 0;
      while (nframes < ((ph == 1) ? 5 : (ph == 3) ? 2 : 1)) begin
        if (ph == 3 && nframes == 1) wait_drained();
        send_frame(random_row());
        nframes++;
      end
      wait_drained();
    end

    $display("covered %0d frames and %0d bytes under %0d register settings plus reset values",
             frames_sent, bytes_sent, settings_done);
    $display("verdicts seen: match %0d, not ipv4 %0d, not tcp %0d, mismatch %0d, truncated %0d",
             verdict_seen[tpf_pkg::VERDICT_MATCH], verdict_seen[tpf_pkg::VERDICT_NOT_IPV4],
             verdict_seen[tpf_pkg::VERDICT_NOT_TCP], verdict_seen[tpf_pkg::VERDICT_MISMATCH],
             verdict_seen[tpf_pkg::VERDICT_TRUNCATED]);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/tpf_pkg.sv
design/tpf_queue.sv
design/tpf_front.sv
design/tpf_back.sv
design/tcp_port_packet_filter.sv
tb/tb_top.sv
